// File: design/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg: shared types and constants of the RPN stack calculator
// Character codes, command and status encodings, and the front/back and
// divider interface structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpn_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CMD_DEPTH   = 2;
  localparam int unsigned CMD_PTR_W   = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_FILL_W  = $clog2(CMD_DEPTH + 1);
  localparam int unsigned STEP_W      = $clog2(DATA_W);

  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [CHAR_W-1:0] CH_TILDE   = 8'h7E;
  localparam logic [CHAR_W-1:0] CH_QUIT    = 8'h71;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;

  typedef enum logic [3:0] {
    OP_PUSH  = 4'd0,
    OP_POP   = 4'd1,
    OP_NEG   = 4'd2,
    OP_CLEAR = 4'd3,
    OP_ADD   = 4'd4,
    OP_SUB   = 4'd5,
    OP_MUL   = 4'd6,
    OP_DIV   = 4'd7,
    OP_MOD   = 4'd8,
    OP_BAD   = 4'd9
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_SHOWN   = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_ERROR   = 3'd2,
    ST_FULL    = 3'd3,
    ST_DIVZERO = 3'd4
  } status_e;

  typedef struct packed {
    op_e               op;
    logic [DIGIT_W-1:0] digit;
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic              is_mod;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } div_rsp_t;

endpackage

// File: design/rpn_ram.sv
// ----------------------------------------------------------------------------
// rpn_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 64,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/rpn_front.sv
// ----------------------------------------------------------------------------
// rpn_front: character decoder and command queue
// Classifies each transferred character into a command and queues it for
// the execution side. Blank characters are dropped here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_front import rpn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  input  logic [CHAR_W-1:0] char_code_i,
  output logic              full,
  output logic              cmd_valid_o,
  output cmd_t              cmd_o,
  input  logic              cmd_pop_i
);

  cmd_t                  entries_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0]  wptr_q, wptr_d;
  logic [CMD_PTR_W-1:0]  rptr_q, rptr_d;
  logic [CMD_FILL_W-1:0] fill_q, fill_d;
  cmd_t                  dec_cmd;
  logic                  dec_skip;
  logic                  wr_en;
  logic                  rd_en;

  always_comb begin
    dec_cmd.op    = OP_BAD;
    dec_cmd.digit = char_code_i[DIGIT_W-1:0];
    dec_skip      = 1'b0;
    unique case (char_code_i) inside
      [CH_ZERO:CH_NINE]:    dec_cmd.op = OP_PUSH;
      CH_DOT:               dec_cmd.op = OP_POP;
      CH_TILDE:             dec_cmd.op = OP_NEG;
      CH_QUIT:              dec_cmd.op = OP_CLEAR;
      CH_PLUS:              dec_cmd.op = OP_ADD;
      CH_MINUS:             dec_cmd.op = OP_SUB;
      CH_STAR:              dec_cmd.op = OP_MUL;
      CH_SLASH:             dec_cmd.op = OP_DIV;
      CH_PERCENT:           dec_cmd.op = OP_MOD;
      CH_SPACE, CH_NEWLINE: dec_skip   = 1'b1;
      default:              dec_cmd.op = OP_BAD;
    endcase
  end

  assign full        = (fill_q == CMD_FILL_W'(CMD_DEPTH));
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = entries_q[rptr_q];
  assign wr_en       = push && !full && !dec_skip;
  assign rd_en       = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (wr_en) begin
      wptr_d = (wptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wptr_q + CMD_PTR_W'(1);
    end
    if (rd_en) begin
      rptr_d = (rptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rptr_q + CMD_PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      fill_d = fill_q + CMD_FILL_W'(1);
    end else if (rd_en && !wr_en) begin
      fill_d = fill_q - CMD_FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entries_q[wptr_q] <= dec_cmd;
    end
  end

endmodule

// File: design/rpn_divider.sv
// ----------------------------------------------------------------------------
// rpn_divider: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, then a sign
// fix. Returns the truncated quotient or the remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_divider import rpn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_RUN  = 3'b010,
    D_FIX  = 3'b100
  } div_state_e;

  div_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] dsr_q, dsr_d;
  logic              neg_q, neg_d;
  logic              mod_q, mod_d;
  logic [DATA_W-1:0] result_q, result_d;
  logic              done_q, done_d;
  logic [DATA_W:0]   trial;
  logic [DATA_W-1:0] mag;

  assign trial = {rem_q, quo_q[DATA_W-1]} - {1'b0, dsr_q};
  assign mag   = mod_q ? rem_q : quo_q;

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    dsr_d    = dsr_q;
    neg_d    = neg_q;
    mod_d    = mod_q;
    result_d = result_q;
    done_d   = 1'b0;
    unique case (state_q)
      D_IDLE: begin
        if (req_i.start) begin
          quo_d   = req_i.dividend[DATA_W-1] ? -req_i.dividend : req_i.dividend;
          dsr_d   = req_i.divisor[DATA_W-1] ? -req_i.divisor : req_i.divisor;
          rem_d   = '0;
          mod_d   = req_i.is_mod;
          neg_d   = req_i.is_mod ? req_i.dividend[DATA_W-1]
                                 : (req_i.dividend[DATA_W-1] ^ req_i.divisor[DATA_W-1]);
          step_d  = '0;
          state_d = D_RUN;
        end
      end
      D_RUN: begin
        if (!trial[DATA_W]) begin
          rem_d = trial[DATA_W-1:0];
          quo_d = {quo_q[DATA_W-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
          quo_d = {quo_q[DATA_W-2:0], 1'b0};
        end
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(DATA_W - 1)) begin
          state_d = D_FIX;
        end
      end
      D_FIX: begin
        result_d = neg_q ? -mag : mag;
        done_d   = 1'b1;
        state_d  = D_IDLE;
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q   <= step_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    dsr_q    <= dsr_d;
    neg_q    <= neg_d;
    mod_q    <= mod_d;
    result_q <= result_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = result_q;

endmodule

// File: design/rpn_back.sv
// ----------------------------------------------------------------------------
// rpn_back: stack execution unit
// Carries out queued commands on the stack: top value in a register, the
// values beneath it in RAM. Holds one finished result for the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_back import rpn_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  cmd_t                cmd_i,
  output logic                cmd_pop_o,
  output div_req_t            div_req_o,
  input  div_rsp_t            div_rsp_i,
  output logic                ram_we_o,
  output logic [ADDR_W-1:0]   ram_waddr_o,
  output logic [DATA_W-1:0]   ram_wdata_o,
  output logic [ADDR_W-1:0]   ram_raddr_o,
  input  logic [DATA_W-1:0]   ram_rdata_i,
  output logic                empty,
  input  logic                pop,
  output logic [STATUS_W-1:0] status_o,
  output logic [DATA_W-1:0]   value_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_OPER = 5'b00100,
    S_WB   = 5'b01000,
    S_DIV  = 5'b10000
  } back_state_e;

  back_state_e       state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  op_e               op_q, op_d;
  logic [DATA_W-1:0] tos_q, tos_d;
  logic [DATA_W-1:0] r_q, r_d;
  logic              res_valid_q, res_valid_d;
  status_e           res_status_q, res_status_d;
  logic [DATA_W-1:0] res_value_q, res_value_d;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;

  assign cnt_m1 = count_q - CNT_W'(1);
  assign cnt_m2 = count_q - CNT_W'(2);

  assign ram_waddr_o = cnt_m1[ADDR_W-1:0];
  assign ram_raddr_o = cnt_m2[ADDR_W-1:0];
  assign ram_wdata_o = tos_q;

  always_comb begin
    state_d             = state_q;
    count_d             = count_q;
    op_d                = op_q;
    tos_d               = tos_q;
    r_d                 = r_q;
    res_valid_d         = res_valid_q && !pop;
    res_status_d        = res_status_q;
    res_value_d         = res_value_q;
    cmd_pop_o           = 1'b0;
    ram_we_o            = 1'b0;
    div_req_o.start     = 1'b0;
    div_req_o.is_mod    = (op_q == OP_MOD);
    div_req_o.dividend  = tos_q;
    div_req_o.divisor   = ram_rdata_i;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && !res_valid_q) begin
          cmd_pop_o   = 1'b1;
          op_d        = cmd_i.op;
          res_value_d = '0;
          unique case (cmd_i.op) inside
            OP_PUSH: begin
              if (count_q == CNT_W'(STACK_DEPTH)) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_FULL;
              end else begin
                // spill the old top below the new one
                ram_we_o = (count_q != '0);
                tos_d    = {{(DATA_W - DIGIT_W){1'b0}}, cmd_i.digit};
                count_d  = count_q + CNT_W'(1);
              end
            end
            OP_POP: begin
              res_valid_d = 1'b1;
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
              end else begin
                res_status_d = ST_SHOWN;
                res_value_d  = tos_q;
                count_d      = cnt_m1;
                if (count_q >= CNT_W'(2)) begin
                  state_d = S_LOAD;
                end
              end
            end
            OP_NEG: begin
              if (count_q == '0) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_ERROR;
              end else begin
                tos_d = -tos_q;
              end
            end
            OP_CLEAR: count_d = '0;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
              if (count_q < CNT_W'(2)) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_ERROR;
              end else begin
                state_d = S_OPER;
              end
            end
            default: begin
              res_valid_d  = 1'b1;
              res_status_d = ST_ERROR;
            end
          endcase
        end
      end
      S_LOAD: begin
        tos_d   = ram_rdata_i;
        state_d = S_IDLE;
      end
      S_OPER: begin
        state_d = S_WB;
        case (op_q)
          OP_ADD:  r_d = tos_q + ram_rdata_i;
          OP_SUB:  r_d = tos_q - ram_rdata_i;
          OP_MUL:  r_d = tos_q * ram_rdata_i;
          default: begin
            if (ram_rdata_i == '0) begin
              res_valid_d  = 1'b1;
              res_status_d = ST_DIVZERO;
              res_value_d  = '0;
              state_d      = S_IDLE;
            end else begin
              div_req_o.start = 1'b1;
              state_d         = S_DIV;
            end
          end
        endcase
      end
      S_WB: begin
        tos_d   = ((op_q == OP_SUB) && r_q[DATA_W-1]) ? -r_q : r_q;
        count_d = cnt_m1;
        state_d = S_IDLE;
      end
      S_DIV: begin
        if (div_rsp_i.done) begin
          tos_d   = div_rsp_i.result;
          count_d = cnt_m1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    tos_q        <= tos_d;
    r_q          <= r_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
  end

  assign empty    = !res_valid_q;
  assign status_o = res_status_q;
  assign value_o  = res_value_q;

endmodule

// File: design/rpn_stack_calculator.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator: postfix calculator on a stack of 32-bit integers
// Top level: character front end, command queue, stack execution unit,
// iterative divider and stack RAM.
// ----------------------------------------------------------------------------
// Characters enter through a queue-style port (push/full) and results leave
// through another (empty/pop). Digits push their value, '.' pops and shows
// the top, + - * / % combine the two top values (top is the left operand,
// '-' gives the absolute difference), '~' negates the top, 'q' clears the
// stack, blanks are dropped. The front end takes one character per cycle
// while not full into a two-entry command queue, which fills while a result
// waits. The execution side works one command at a time: push, negate,
// clear, a pop of the last value and decode errors end in the idle state;
// a pop that exposes a stored value adds a RAM load state; divide or modulo
// by zero ends in the operand state; add, subtract and multiply then write
// back; divide and modulo wait on the divider's one-bit-per-cycle loop over
// 32 bits. While a result waits, no command starts; execution resumes once
// that result has been popped. No clearing pass runs after reset; the stack
// RAM is only read at entries that a push has written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_stack_calculator import rpn_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [CHAR_W-1:0]          char_code_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [STATUS_W-1:0]        status_o,
  output logic signed [DATA_W-1:0]   value_o
);

  // front to back command transfer
  logic     cmd_valid;
  cmd_t     cmd;
  logic     cmd_pop;

  // divider handshake
  div_req_t div_req;
  div_rsp_t div_rsp;

  // stack RAM holds every value below the top
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic [DATA_W-1:0] value;

  rpn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .char_code_i (char_code_i),
    .full        (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  rpn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .empty       (empty),
    .pop         (pop),
    .status_o    (status_o),
    .value_o     (value)
  );

  rpn_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  rpn_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign value_o = signed'(value);

endmodule

// File: design/rpn_checker.sv
// ----------------------------------------------------------------------------
// rpn_checker: port-level checks for the RPN stack calculator
// Watches the result port over time; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_checker import rpn_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     push,
  input logic                     full,
  input logic [CHAR_W-1:0]        char_code_i,
  input logic                     empty,
  input logic                     pop,
  input logic [STATUS_W-1:0]      status_o,
  input logic signed [DATA_W-1:0] value_o
);

  // only a shown top carries a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (status_o != ST_SHOWN)) |-> (value_o == '0))
    else $error("nonzero value on a status-only result");

  // status stays within the defined codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (status_o == ST_SHOWN || status_o == ST_EMPTY ||
                status_o == ST_ERROR || status_o == ST_FULL ||
                status_o == ST_DIVZERO))
    else $error("undefined status code");

  // hold a waiting result until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(value_o)))
    else $error("result dropped or changed before transfer");

endmodule

bind rpn_stack_calculator rpn_checker u_checker (.*);

// File: bench/rpn_stack_calculator_tb.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator_tb: self-checking regression of the RPN calculator
// Feeds character streams through the push/full port and checks every
// transfer on the empty/pop port against a cycle-free shadow of the stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_stack_calculator_tb;
  import rpn_pkg::*;

  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned RANDOM_CHARS = 1750;
  // Longest command is a divide; leave plenty of slack behind it.
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned MAX_PRINTED  = 40;

  typedef struct {
    logic [CHAR_W-1:0] code;
    bit                wait_idle;  // hold this char until no result is due
  } feed_item_t;

  typedef struct {
    status_e           status;
    logic [DATA_W-1:0] value;
  } calc_result_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     push        = 1'b0;
  logic                     full;
  logic [CHAR_W-1:0]        char_code_i = '0;
  logic                     empty;
  logic                     pop         = 1'b0;
  logic [STATUS_W-1:0]      status_o;
  logic signed [DATA_W-1:0] value_o;

  // Characters waiting to be offered, and results owed by the block.
  feed_item_t   char_feed[$];
  calc_result_t results_due[$];

  // Shadow copy of the calculator state.
  logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
  int unsigned       shadow_depth = 0;

  // Sender and receiver pacing.
  bit          in_xfer       = 1'b0;
  bit          mark_next     = 1'b0;
  int unsigned burst_left    = 8;
  int unsigned gap_left      = 0;
  int unsigned hold_left     = 0;
  int unsigned next_hold_at  = 30;
  int unsigned stall_phase   = 0;
  logic [15:0] pop_pattern   = 16'hFFFF;

  // Bookkeeping.
  int unsigned cycle_count     = 0;
  int unsigned chars_sent      = 0;
  int unsigned directed_chars  = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count  = 0;
  int unsigned long_holds      = 0;
  int unsigned drain_pauses    = 0;
  int unsigned status_seen [5] = '{default: 0};

  rpn_stack_calculator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .char_code_i (char_code_i),
    .empty       (empty),
    .pop         (pop),
    .status_o    (status_o),
    .value_o     (value_o)
  );

  initial begin : clock_gen
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // --------------------------------------------------------------------------
  // Shadow calculator: apply one accepted character and queue its result.
  // Top of stack is the left operand; divide and modulo go through 64 bits
  // so that the most negative value over minus one wraps instead of trapping.
  // --------------------------------------------------------------------------
  task automatic execute_char(input logic [CHAR_W-1:0] c);
    logic [DATA_W-1:0] a, b, r;
    longint            sa, sb;
    bit                has_res;
    bit                do_store;
    calc_result_t      res;
    has_res    = 1'b0;
    do_store   = 1'b1;
    r          = '0;
    res.status = ST_ERROR;
    res.value  = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (shadow_depth >= STACK_DEPTH) begin
        has_res    = 1'b1;
        res.status = ST_FULL;
      end else begin
        shadow_stack[shadow_depth] = DATA_W'(c - CH_ZERO);
        shadow_depth++;
      end
    end else if (c == CH_DOT) begin
      has_res = 1'b1;
      if (shadow_depth == 0) begin
        res.status = ST_EMPTY;
      end else begin
        shadow_depth--;
        res.status = ST_SHOWN;
        res.value  = shadow_stack[shadow_depth];
      end
    end else if (c == CH_SPACE || c == CH_NEWLINE) begin
      // blanks are dropped silently
    end else if (c == CH_QUIT) begin
      shadow_depth = 0;
    end else if (c == CH_TILDE) begin
      if (shadow_depth == 0) has_res = 1'b1;
      else shadow_stack[shadow_depth - 1] = -shadow_stack[shadow_depth - 1];
    end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR ||
                 c == CH_SLASH || c == CH_PERCENT) begin
      if (shadow_depth < 2) begin
        has_res = 1'b1;
      end else begin
        a  = shadow_stack[shadow_depth - 1];
        b  = shadow_stack[shadow_depth - 2];
        sa = longint'(signed'(a));
        sb = longint'(signed'(b));
        case (c)
          CH_PLUS:  r = a + b;
          CH_MINUS: begin
            r = a - b;
            if (r[DATA_W-1]) r = -r;  // the most negative value stays put
          end
          CH_STAR:  r = a * b;
          default: begin
            if (sb == 0) begin
              // operands stay on the stack
              do_store   = 1'b0;
              has_res    = 1'b1;
              res.status = ST_DIVZERO;
            end else if (c == CH_SLASH) begin
              r = DATA_W'(sa / sb);
            end else begin
              r = DATA_W'(sa % sb);
            end
          end
        endcase
        if (do_store) begin
          shadow_depth--;
          shadow_stack[shadow_depth - 1] = r;
        end
      end
    end else begin
      has_res = 1'b1;  // unknown character
    end
    if (has_res) results_due.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    if (mismatch_count < MAX_PRINTED)
      $display("%0t ns: mismatch on %s: got 0x%08h, want 0x%08h", $time, what, got, want);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Monitor: sample both handshakes at the rising edge. Inputs are stable
  // here since they only move at the falling edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    calc_result_t due;
    in_xfer = rst_ni && push && !full;
    if (in_xfer) execute_char(char_code_i);
    if (rst_ni && pop && !empty) begin
      if (results_due.size() == 0) begin
        report_mismatch("result with nothing due", DATA_W'(status_o), '0);
      end else begin
        due = results_due.pop_front();
        if (status_o !== due.status)
          report_mismatch("status", DATA_W'(status_o), DATA_W'(due.status));
        if (value_o !== due.value)
          report_mismatch("value", value_o, due.value);
        status_seen[int'(due.status)]++;
        results_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender: drop the char once its transfer is seen, then work in bursts of
  // random length separated by random gaps. A marked char is held back
  // until every result owed so far has been popped.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : sender
    logic nxt_push;
    if (rst_ni) begin
      if (in_xfer) begin
        char_feed.delete(0);
        chars_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          burst_left = $urandom_range(1, 24);
        end
      end
      nxt_push = 1'b0;
      if (gap_left > 0)
        gap_left--;
      else if (char_feed.size() > 0 &&
               !(char_feed[0].wait_idle && results_due.size() > 0))
        nxt_push = 1'b1;
      push <= nxt_push;
      if (nxt_push) char_code_i <= char_feed[0].code;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: pop on a rotating pattern that is redrawn at random (sometimes
  // all ones), and now and then hold off while a result waits, so that the
  // command queue fills and full rises.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : receiver
    if (rst_ni) begin
      stall_phase++;
      if (stall_phase % 64 == 0)
        pop_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h1);
      if (hold_left == 0 && !empty && results_checked >= next_hold_at) begin
        hold_left    = $urandom_range(300, 600);
        next_hold_at = results_checked + $urandom_range(250, 450);
        long_holds++;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= pop_pattern[0];
        pop_pattern = {pop_pattern[0], pop_pattern[15:1]};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  task automatic feed_char(input logic [CHAR_W-1:0] code);
    feed_item_t item;
    item.code      = code;
    item.wait_idle = mark_next;
    mark_next      = 1'b0;
    char_feed.push_back(item);
  endtask

  task automatic feed_text(input string s);
    for (int i = 0; i < s.len(); i++) feed_char(s[i]);
  endtask

  function automatic logic [CHAR_W-1:0] pick_digit();
    return CH_ZERO + CHAR_W'($urandom_range(0, 9));
  endfunction

  function automatic logic [CHAR_W-1:0] pick_operator();
    case ($urandom_range(0, 4))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      default: return CH_PERCENT;
    endcase
  endfunction

  // Well-formed expression: operands with operators applied as they go or
  // at the end, then a pop of the answer.
  task automatic feed_expression();
    int unsigned n_operands;
    int unsigned ops_owed;
    n_operands = $urandom_range(2, 6);
    ops_owed   = 0;
    feed_char(pick_digit());
    for (int i = 1; i < n_operands; i++) begin
      feed_char(pick_digit());
      ops_owed++;
      if ($urandom_range(0, 4) == 0) feed_char(CH_TILDE);
      if ($urandom_range(0, 5) == 0) feed_char(CH_SPACE);
      if ($urandom_range(0, 1) == 0) begin
        feed_char(pick_operator());
        ops_owed--;
      end
    end
    while (ops_owed > 0) begin
      feed_char(pick_operator());
      ops_owed--;
    end
    feed_char(CH_DOT);
    if ($urandom_range(0, 7) == 0) feed_char(CH_DOT);
    if ($urandom_range(0, 9) == 0) feed_char(CH_NEWLINE);
  endtask

  // Product chains that push values across the whole 32-bit range.
  task automatic feed_wide_value();
    int unsigned n_steps;
    n_steps = $urandom_range(3, 12);
    feed_char(CH_NINE);
    for (int i = 0; i < n_steps; i++) begin
      feed_char(CH_ZERO + CHAR_W'($urandom_range(1, 9)));
      feed_char(($urandom_range(0, 4) == 0) ? CH_PLUS : CH_STAR);
    end
    if ($urandom_range(0, 2) == 0) feed_char(CH_TILDE);
    feed_char(CH_DOT);
  endtask

  // Build the most negative value (2 * 8^10 wraps to -2^31) on top of a
  // chosen operand and hit it with divide, modulo, difference or negate.
  task automatic feed_most_negative();
    int unsigned variant;
    variant = $urandom_range(0, 3);
    if (variant <= 1) feed_text("1~");
    else if (variant == 2) feed_char(CH_ZERO);
    feed_char(CH_ZERO + CHAR_W'(2));
    for (int i = 0; i < 10; i++) feed_text("8*");
    case (variant)
      0:       feed_char(CH_SLASH);
      1:       feed_char(CH_PERCENT);
      2:       feed_char(CH_MINUS);
      default: feed_char(CH_TILDE);
    endcase
    feed_char(CH_DOT);
  endtask

  // Push to near or past the stack depth, then clear it.
  task automatic feed_overflow();
    int unsigned n_pushes;
    int unsigned n_pops;
    n_pushes = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 6);
    n_pops   = $urandom_range(0, 3);
    feed_char(CH_QUIT);
    for (int i = 0; i < n_pushes; i++) feed_char(pick_digit());
    for (int i = 0; i < n_pops; i++) feed_char(CH_DOT);
    feed_char(CH_QUIT);
  endtask

  // Out-of-order fragments of valid characters.
  task automatic feed_broken();
    int unsigned n_chars;
    n_chars = $urandom_range(1, 5);
    for (int i = 0; i < n_chars; i++) begin
      case ($urandom_range(0, 3))
        0:       feed_char(pick_operator());
        1:       feed_char(CH_DOT);
        2:       feed_char(CH_TILDE);
        default: feed_char(pick_digit());
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    int unsigned next_mark;
    int unsigned pick;
    int unsigned n_noise;

    // Directed: empty pop, too few operands, codes at both ends of the byte,
    // negate, difference, divide and modulo by zero, blanks, clear, and one
    // successful operation of each kind.
    feed_text(".~+");
    feed_char(8'h00);
    feed_char(8'hFF);
    feed_text("5~.37-.09/%*.q 1\n2+.48/6%.");
    directed_chars = char_feed.size();

    next_mark = directed_chars;
    while (char_feed.size() < directed_chars + RANDOM_CHARS) begin
      if (char_feed.size() >= next_mark) begin
        mark_next = 1'b1;
        drain_pauses++;
        next_mark += $urandom_range(150, 250);
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        feed_expression();
      end else if (pick < 65) begin
        feed_wide_value();
      end else if (pick < 70) begin
        feed_most_negative();
      end else if (pick < 73) begin
        feed_overflow();
      end else if (pick < 85) begin
        n_noise = $urandom_range(1, 4);
        for (int i = 0; i < n_noise; i++) feed_char(CHAR_W'($urandom_range(0, 255)));
      end else if (pick < 93) begin
        feed_broken();
      end else begin
        case ($urandom_range(0, 2))
          0:       feed_char(CH_QUIT);
          1:       feed_char(CH_SPACE);
          default: feed_char(CH_NEWLINE);
        endcase
      end
    end

    // Hold reset, then release it away from the rising edge.
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every char to transfer and every owed result to pop, then
    // give the block time to show any stray result.
    while (char_feed.size() != 0 || results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    foreach (results_due[i])
      report_mismatch("result never delivered", '0, results_due[i].value);

    $display("Covered %0d chars (%0d directed) and %0d results: %0d shown, %0d empty,",
             chars_sent, directed_chars, results_checked, status_seen[0], status_seen[1]);
    $display("  %0d error, %0d full, %0d divide by zero; %0d long pop holds, %0d drain pauses.",
             status_seen[2], status_seen[3], status_seen[4], long_holds, drain_pauses);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
